// File: hw/rtl/hk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hk_pkg;

    localparam int unsigned Letters = 26;
    localparam int unsigned LetW    = 5;
    localparam int unsigned ProdW   = 11;
    // floor(x * RecipMul / 2**RecipSh) is floor(x / 26) or one less for x < 2048
    localparam int unsigned RecipMul = 315;
    localparam int unsigned RecipSh  = 13;
    localparam int unsigned RecipW   = ProdW + 9;

    typedef logic [LetW-1:0] t_let;
    typedef t_let [3:0] t_mat;     // row-major: index row * 2 + column

    typedef struct packed {
        logic found;
        t_let inv;
        t_mat adj;
        t_mat cm;
    } t_front_item;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;

    // Reduce a value below 2048 into 0..25.
    function automatic t_let mod26(input logic [ProdW-1:0] x);
        logic [RecipW-1:0] prod;
        logic [ProdW-1:0]  q;
        logic [ProdW-1:0]  r;
        prod = RecipW'(x) * RecipW'(RecipMul);
        q    = ProdW'(prod >> RecipSh);
        r    = x - ProdW'(q * ProdW'(Letters));
        if (r >= ProdW'(Letters)) begin
            r = r - ProdW'(Letters);
        end
        return LetW'(r);
    endfunction

    function automatic t_let mul_mod(input t_let a, input t_let b);
        return mod26(ProdW'(a) * ProdW'(b));
    endfunction

    // Fold a raw 5-bit letter into 0..25.
    function automatic t_let fold(input t_let x);
        return (x >= LetW'(Letters)) ? x - LetW'(Letters) : x;
    endfunction

    // Additive inverse of a residue 0..25.
    function automatic t_let neg26(input t_let x);
        return (x == '0) ? '0 : LetW'(Letters) - x;
    endfunction

    // Multiplicative inverse mod 26; zero marks a residue with no inverse.
    function automatic t_let inv26(input t_let x);
        t_let r;
        case (x)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hk_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hk_front import hk_pkg::*; (
    input  wire t_mat        i_plain,
    input  wire t_mat        i_cipher,
    output t_front_item      o_item
);

    t_mat p;
    t_let a;
    t_let b;
    t_let det;
    t_let inv;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            p[k]         = fold(i_plain[k]);
            o_item.cm[k] = fold(i_cipher[k]);
        end
        a   = mul_mod(p[0], p[3]);
        b   = mul_mod(p[1], p[2]);
        det = (a >= b) ? a - b : a + LetW'(Letters) - b;
        inv = inv26(det);
        o_item.inv    = inv;
        o_item.found  = (inv != '0);
        o_item.adj[0] = p[3];
        o_item.adj[1] = neg26(p[1]);
        o_item.adj[2] = neg26(p[2]);
        o_item.adj[3] = p[0];
    end

endmodule

`default_nettype wire

// File: hw/rtl/hk_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module hk_queue import hk_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    output logic        o_full,
    input  wire t_front_item i_item,
    input  wire         i_pop,
    output logic        o_empty,
    output t_front_item o_item
);

    t_front_item r_mem [2];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_cnt;
    logic        do_push;
    logic        do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wr <= !r_wr;
            if (do_pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count overflow");

    a_ptr_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) == (r_wr != r_rd))
        else $error("queue pointers disagree with count");

    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !do_pop) |=> o_full)
        else $error("full queue lost an entry without a pop");

endmodule

`default_nettype wire

// File: hw/rtl/hk_back.sv
`timescale 1ns / 1ps
`default_nettype none

module hk_back import hk_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire t_front_item i_item,
    output t_hs         o_hs_out,
    input  wire         i_out_ready,
    output t_mat        o_key,
    output logic        o_found
);

    // stage 1: inverse of P
    logic r_v1;
    t_mat r_cm;
    t_mat r_pi;
    logic r_found1;
    // stage 2: key product, doubles as output register
    logic r_v2;
    t_mat r_key;
    logic r_found2;

    t_mat n_pi;
    t_mat n_key;
    logic adv1;
    logic adv2;

    assign adv2    = !r_v2 || i_out_ready;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_pi[k] = mul_mod(i_item.adj[k], i_item.inv);
        end
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                n_key[i*2+j] = r_found1
                    ? mod26(ProdW'(r_cm[i*2]) * ProdW'(r_pi[j])
                          + ProdW'(r_cm[i*2+1]) * ProdW'(r_pi[2+j]))
                    : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) begin
            r_cm     <= i_item.cm;
            r_pi     <= n_pi;
            r_found1 <= i_item.found;
        end
        if (adv2 && r_v1) begin
            r_key    <= n_key;
            r_found2 <= r_found1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
        end
    end

    assign o_hs_out.valid = r_v2;
    assign o_hs_out.ready = adv2;
    assign o_key          = r_key;
    assign o_found        = r_found2;

    a_zero_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !r_found2) |-> (r_key == '0))
        else $error("key not cleared for singular plaintext");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !i_out_ready) |=> (r_v2 && $stable(r_key) && $stable(r_found2)))
        else $error("stalled result changed");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && adv2) |=> r_v2)
        else $error("stage 1 item dropped");

endmodule

`default_nettype wire

// File: hw/rtl/hill_2x2_key_recovery.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: queue, then stage 1, then stage 2, which drives the master side.
// Throughput: one item per cycle while m_axis_tready is high; a 2-entry queue parts the
// classify front from the two-stage key pipeline, so each side stalls on its own.
// Reset: synchronous, active low; clears queue pointers and pipeline valids, not data.

module hill_2x2_key_recovery import hk_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // plain_r0c0, plain_r0c1, plain_r1c0, plain_r1c1,
    // cipher_r0c0, cipher_r0c1, cipher_r1c0, cipher_r1c1 (5 bits each)
    input  wire [39:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // key_r0c0, key_r0c1, key_r1c0, key_r1c1 (5 bits each), 4 bits zero
    output logic [23:0] m_axis_tdata,
    // key_found
    output logic        m_axis_tuser
);

    t_mat        plain;
    t_mat        cipher;
    t_front_item f_item;
    t_front_item q_item;
    logic        q_full;
    logic        q_empty;
    logic        back_ready;
    t_hs         out_hs;
    t_mat        key;
    logic        found;

    assign plain  = s_axis_tdata[19:0];
    assign cipher = s_axis_tdata[39:20];

    hk_front u_front (
        .i_plain  (plain),
        .i_cipher (cipher),
        .o_item   (f_item)
    );

    hk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .o_full  (q_full),
        .i_item  (f_item),
        .i_pop   (back_ready),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    hk_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!q_empty),
        .o_ready     (back_ready),
        .i_item      (q_item),
        .o_hs_out    (out_hs),
        .i_out_ready (m_axis_tready),
        .o_key       (key),
        .o_found     (found)
    );

    assign s_axis_tready = !q_full;
    assign m_axis_tvalid = out_hs.valid;
    assign m_axis_tdata  = {4'b0, key};
    assign m_axis_tuser  = found;

endmodule

`default_nettype wire
